[rtl/trd_pkg.sv]
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the touch report decoder: the report job
// handed from the byte front end to the calibration back end, the
// calibration register set and the edge and register index codes.
// ----------------------------------------------------------------------------
package trd_pkg;

  // report framing
  localparam int unsigned ReportLen  = 5;
  localparam int unsigned IdxW       = 3;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ReportLen - 1);
  localparam int unsigned SyncBit    = 7;
  localparam int unsigned TouchBit   = 6;

  // field widths
  localparam int unsigned RawW       = 15;
  localparam int unsigned SpanW      = 13;
  localparam int unsigned PosW       = 16;
  localparam int unsigned CfgDataW   = 16;

  // divider: magnitude of the scaled numerator fits in 30 bits, two bits a cycle
  localparam int unsigned DivW       = 30;
  localparam int unsigned DivSteps   = DivW / 2;
  localparam int unsigned DivCntW    = 4;
  localparam int unsigned ProdW      = 30;

  // register reset values
  localparam logic [SpanW-1:0] SpanXRst    = SpanW'(640);
  localparam logic [SpanW-1:0] SpanYRst    = SpanW'(480);
  localparam logic [RawW-1:0]  CalXLowRst  = RawW'(19);
  localparam logic [RawW-1:0]  CalXHighRst = RawW'(946);
  localparam logic [RawW-1:0]  CalYLowRst  = RawW'(1001);
  localparam logic [RawW-1:0]  CalYHighRst = RawW'(62);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SPAN_X        = 3'd0,
    REG_SPAN_Y        = 3'd1,
    REG_CAL_X_LOW     = 3'd2,
    REG_CAL_X_HIGH    = 3'd3,
    REG_CAL_Y_LOW     = 3'd4,
    REG_CAL_Y_HIGH    = 3'd5,
    REG_FLIP_X_BASE   = 3'd6,
    REG_FLIP_Y_BASE   = 3'd7
  } cfg_reg_e;

  // press/release edge codes
  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } edge_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_PREP,
    CS_DIV,
    CS_FIN,
    CS_DONE
  } calib_st_e;

  // one decoded report waiting for calibration
  typedef struct packed {
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
    logic            touching;
    edge_e           button_edge;
  } job_t;

  // calibration register set
  typedef struct packed {
    logic [SpanW-1:0] span_x;
    logic [SpanW-1:0] span_y;
    logic [RawW-1:0]  cal_x_low;
    logic [RawW-1:0]  cal_x_high;
    logic [RawW-1:0]  cal_y_low;
    logic [RawW-1:0]  cal_y_high;
    logic [PosW-1:0]  flip_x_base;
    logic [PosW-1:0]  flip_y_base;
  } cfg_t;

endpackage

[rtl/trd_front.sv]
// ----------------------------------------------------------------------------
// trd_front
// Byte front end: collects five-byte reports, drops reports without the
// sync bit, derives touch state and press/release edge and pushes a job
// with the raw x and y readings into the queue.
// ----------------------------------------------------------------------------
module trd_front import trd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output job_t        job_o
);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      header_q;
  logic [7:0]      body_q [3];
  logic            pressed_q, pressed_d;
  logic            accept;
  logic            last_byte;
  logic            touch;

  // only the closing byte of a synced report needs queue space
  assign last_byte  = (idx_q == LastIdx);
  assign in_ready_o = !last_byte || !header_q[SyncBit] || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && last_byte && header_q[SyncBit];
  assign touch      = header_q[TouchBit];

  // byte position and touch state
  always_comb begin
    idx_d     = idx_q;
    pressed_d = pressed_q;
    if (accept) begin
      idx_d = last_byte ? '0 : idx_q + IdxW'(1);
    end
    if (push_o) begin
      pressed_d = touch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      header_q  <= '0;
      pressed_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      pressed_q <= pressed_d;
      if (accept && idx_q == '0) begin
        header_q <= rx_byte_i;
      end
    end
  end

  // report body bytes one to three; byte four is taken straight from the port
  always_ff @(posedge clk_i) begin
    if (accept && idx_q != '0 && !last_byte) begin
      body_q[2'(idx_q - IdxW'(1))] <= rx_byte_i;
    end
  end

  // job assembly, the high byte's bit 0 overlaps bit 7 of the low byte
  always_comb begin
    job_o.raw_y    = {body_q[0], 7'b0} | {7'b0, body_q[1]};
    job_o.raw_x    = {body_q[2], 7'b0} | {7'b0, rx_byte_i};
    job_o.touching = touch;
    if (touch && !pressed_q) begin
      job_o.button_edge = EDGE_PRESS;
    end else if (!touch && pressed_q) begin
      job_o.button_edge = EDGE_RELEASE;
    end else begin
      job_o.button_edge = EDGE_NONE;
    end
  end

endmodule

[rtl/trd_queue.sv]
// ----------------------------------------------------------------------------
// trd_queue
// Small job queue between the byte front end and the calibration back end.
// ----------------------------------------------------------------------------
module trd_queue import trd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  push_ready_o,
  input  job_t  push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output job_t  pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/trd_calib.sv]
// ----------------------------------------------------------------------------
// trd_calib
// Calibration back end: per axis one multiply, then a two-bit-per-cycle restoring
// divide for span*(raw-low)/(high-low) rounded half up and truncated toward zero
// (raw passed through if low equals high), then optional flip; x first, then y.
// ----------------------------------------------------------------------------
module trd_calib import trd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             job_valid_i,
  output logic             job_pop_o,
  input  job_t             job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PosW-1:0]  x_pos_o,
  output logic [PosW-1:0]  y_pos_o,
  output logic             touching_o,
  output logic [1:0]       button_edge_o
);

  calib_st_e              state_q, state_d;
  job_t                   job_q;
  logic                   axis_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [PosW-1:0] diff_q;
  logic [DivW-1:0]        dvd_q;
  logic [PosW-1:0]        den_q;
  logic [PosW-1:0]        rem_q;
  logic                   neg_q;
  logic [DivCntW-1:0]     cnt_q;
  logic [PosW-1:0]        x_work_q;
  logic                   out_valid_q;
  logic [PosW-1:0]        x_pos_q, y_pos_q;
  logic                   touching_q;
  edge_e                  edge_q;

  logic [RawW-1:0]        raw;
  logic [SpanW-1:0]       span;
  logic [RawW-1:0]        lo, hi;
  logic [PosW-1:0]        flip;
  logic signed [PosW-1:0] raw_off;
  logic signed [31:0]     num, num_adj;
  logic [31:0]            num_mag;
  logic [PosW-1:0]        diff_mag;
  logic [PosW:0]          t1, t2;
  logic                   ge1, ge2;
  logic [PosW-1:0]        r1, r2;
  logic [PosW-1:0]        q_val, v_fin;
  logic                   load_out;

  // axis operand select
  always_comb begin
    raw  = axis_q ? job_q.raw_y       : job_q.raw_x;
    span = axis_q ? cfg_i.span_y      : cfg_i.span_x;
    lo   = axis_q ? cfg_i.cal_y_low   : cfg_i.cal_x_low;
    hi   = axis_q ? cfg_i.cal_y_high  : cfg_i.cal_x_high;
    flip = axis_q ? cfg_i.flip_y_base : cfg_i.flip_x_base;
  end

  assign raw_off = $signed({1'b0, raw}) - $signed({1'b0, lo});

  // numerator 2n + d with the divisor sign folded in
  always_comb begin
    num      = $signed({prod_q[ProdW-1], prod_q, 1'b0}) + 32'(diff_q);
    num_adj  = diff_q[PosW-1] ? -num : num;
    num_mag  = num_adj[31] ? 32'(-num_adj) : 32'(num_adj);
    diff_mag = diff_q[PosW-1] ? PosW'(-diff_q) : PosW'(diff_q);
  end

  // two restoring divide steps
  always_comb begin
    t1  = {rem_q, dvd_q[DivW-1]};
    ge1 = (t1 >= {1'b0, den_q});
    r1  = ge1 ? PosW'(t1 - {1'b0, den_q}) : t1[PosW-1:0];
    t2  = {r1, dvd_q[DivW-2]};
    ge2 = (t2 >= {1'b0, den_q});
    r2  = ge2 ? PosW'(t2 - {1'b0, den_q}) : t2[PosW-1:0];
  end

  // sign restore and flip
  always_comb begin
    q_val = neg_q ? PosW'(-dvd_q[PosW-1:0]) : dvd_q[PosW-1:0];
    v_fin = (flip != '0) ? PosW'(flip - q_val) : q_val;
  end

  // sequencer next state and handshakes
  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      CS_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = CS_MUL;
        end
      end
      CS_MUL: begin
        state_d = (lo == hi) ? CS_FIN : CS_PREP;
      end
      CS_PREP: begin
        state_d = CS_DIV;
      end
      CS_DIV: begin
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = CS_FIN;
        end
      end
      CS_FIN: begin
        state_d = axis_q ? CS_DONE : CS_MUL;
      end
      CS_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        job_q  <= job_i;
        axis_q <= 1'b0;
      end
      CS_MUL: begin
        // raw mode passes the reading through the divider registers untouched
        prod_q <= $signed(ProdW'(span)) * ProdW'(raw_off);
        diff_q <= $signed({1'b0, hi}) - $signed({1'b0, lo});
        dvd_q  <= DivW'(raw);
        neg_q  <= 1'b0;
      end
      CS_PREP: begin
        neg_q <= num_adj[31];
        dvd_q <= num_mag[DivW-1:0];
        den_q <= {diff_mag[PosW-2:0], 1'b0};
        rem_q <= '0;
        cnt_q <= '0;
      end
      CS_DIV: begin
        dvd_q <= {dvd_q[DivW-3:0], ge1, ge2};
        rem_q <= r2;
        cnt_q <= cnt_q + DivCntW'(1);
      end
      CS_FIN: begin
        axis_q <= 1'b1;
        if (!axis_q) begin
          x_work_q <= v_fin;
        end else begin
          y_pos_q <= v_fin;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      x_pos_q    <= x_work_q;
      touching_q <= job_q.touching;
      edge_q     <= job_q.button_edge;
    end
  end

  // y is parked in y_pos_q before load; hold it separately from the output
  logic [PosW-1:0] y_out_q;
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      y_out_q <= y_pos_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign x_pos_o       = x_pos_q;
  assign y_pos_o       = y_out_q;
  assign touching_o    = touching_q;
  assign button_edge_o = edge_q;

endmodule

[rtl/touch_report_decoder_unit.sv]
// Flow: the fifth byte of a synced report queues a job; the back end pops it,
//   works x then y (an axis in raw mode skips the divide) and loads the output.
// Throughput: one byte per cycle while the job queue has room; the back end takes
//   one report at a time through the shared 2-bit-per-cycle divider (one multiply,
//   one prep, the divide steps and one finish per axis, plus pop and load).
// Reset: asynchronous, active low; state and config regs reset, no clearing pass.
// ----------------------------------------------------------------------------
// touch_report_decoder_unit
// Five-byte touch report decoder with per-axis calibration and flip.
// ----------------------------------------------------------------------------
module touch_report_decoder_unit import trd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PosW-1:0]     x_pos_o,
  output logic [PosW-1:0]     y_pos_o,
  output logic                touching_o,
  output logic [1:0]          button_edge_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  job_t front_job, queue_job;
  logic q_push, q_push_ready, q_pop_valid, q_pop;

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.span_x      <= SpanXRst;
      cfg_q.span_y      <= SpanYRst;
      cfg_q.cal_x_low   <= CalXLowRst;
      cfg_q.cal_x_high  <= CalXHighRst;
      cfg_q.cal_y_low   <= CalYLowRst;
      cfg_q.cal_y_high  <= CalYHighRst;
      cfg_q.flip_x_base <= '0;
      cfg_q.flip_y_base <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SPAN_X:      cfg_q.span_x      <= cfg_data_i[SpanW-1:0];
        REG_SPAN_Y:      cfg_q.span_y      <= cfg_data_i[SpanW-1:0];
        REG_CAL_X_LOW:   cfg_q.cal_x_low   <= cfg_data_i[RawW-1:0];
        REG_CAL_X_HIGH:  cfg_q.cal_x_high  <= cfg_data_i[RawW-1:0];
        REG_CAL_Y_LOW:   cfg_q.cal_y_low   <= cfg_data_i[RawW-1:0];
        REG_CAL_Y_HIGH:  cfg_q.cal_y_high  <= cfg_data_i[RawW-1:0];
        REG_FLIP_X_BASE: cfg_q.flip_x_base <= cfg_data_i;
        REG_FLIP_Y_BASE: cfg_q.flip_y_base <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // byte front end
  trd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .push_o       (q_push),
    .push_ready_i (q_push_ready),
    .job_o        (front_job)
  );

  // job queue
  trd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (q_push),
    .push_ready_o (q_push_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (q_pop_valid),
    .pop_i        (q_pop),
    .pop_data_o   (queue_job)
  );

  // calibration back end
  trd_calib u_calib (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .job_valid_i   (q_pop_valid),
    .job_pop_o     (q_pop),
    .job_i         (queue_job),
    .out_valid_o,
    .out_ready_i,
    .x_pos_o,
    .y_pos_o,
    .touching_o,
    .button_edge_o
  );

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_push_ready)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_pop_valid)
    else $error("job popped from an empty queue");

  a_press_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && button_edge_o == EDGE_PRESS) |-> touching_o)
    else $error("press edge without touch");

  a_release_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && button_edge_o == EDGE_RELEASE) |-> !touching_o)
    else $error("release edge while touching");

endmodule
